// ===== design/ppcrp_pkg.sv =====
// Shared types, kind codes and constants of the PPC64 relocation patch unit.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package ppcrp_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [63:0] TOC_BIAS   = 64'h0000_0000_0000_8000;
  localparam logic [31:0] REL24_MASK = 32'h03FF_FFFC;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GOT_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLT_ADDRESS = 2'd1;

  // Relocation kind codes as presented on req_type
  localparam logic [4:0] KIND_ADDR32          = 5'd0;
  localparam logic [4:0] KIND_ADDR16          = 5'd1;
  localparam logic [4:0] KIND_ADDR16_LO       = 5'd2;
  localparam logic [4:0] KIND_ADDR16_HI       = 5'd3;
  localparam logic [4:0] KIND_ADDR16_HA       = 5'd4;
  localparam logic [4:0] KIND_ADDR14          = 5'd5;
  localparam logic [4:0] KIND_REL24           = 5'd6;
  localparam logic [4:0] KIND_REL32           = 5'd7;
  localparam logic [4:0] KIND_ADDR64          = 5'd8;
  localparam logic [4:0] KIND_ADDR16_HIGHER   = 5'd9;
  localparam logic [4:0] KIND_ADDR16_HIGHERA  = 5'd10;
  localparam logic [4:0] KIND_ADDR16_HIGHEST  = 5'd11;
  localparam logic [4:0] KIND_ADDR16_HIGHESTA = 5'd12;
  localparam logic [4:0] KIND_REL64           = 5'd13;
  localparam logic [4:0] KIND_TOC16           = 5'd14;
  localparam logic [4:0] KIND_TOC16_LO        = 5'd15;
  localparam logic [4:0] KIND_TOC16_HI        = 5'd16;
  localparam logic [4:0] KIND_TOC16_HA        = 5'd17;
  localparam logic [4:0] KIND_TOC             = 5'd18;
  localparam logic [4:0] KIND_ADDR16_DS       = 5'd19;
  localparam logic [4:0] KIND_ADDR16_LO_DS    = 5'd20;
  localparam logic [4:0] KIND_TOC16_DS        = 5'd21;
  localparam logic [4:0] KIND_TOC16_LO_DS     = 5'd22;
  localparam logic [4:0] KIND_REL16_LO        = 5'd23;
  localparam logic [4:0] KIND_REL16_HI        = 5'd24;
  localparam logic [4:0] KIND_REL16_HA        = 5'd25;

  typedef enum logic [1:0] {
    FORM_HALF_AT_OFS  = 2'd0,
    FORM_HALF_AT_OFS2 = 2'd1,
    FORM_WORD32       = 2'd2,
    FORM_DWORD64      = 2'd3
  } form_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_OVERFLOW   = 2'd1,
    STAT_MISALIGNED = 2'd2,
    STAT_UNKNOWN    = 2'd3
  } status_t;

  // Operation the back end carries out, after TOC kinds are folded
  typedef enum logic [4:0] {
    OP_ADDR32,
    OP_LO,
    OP_HI,
    OP_HA,
    OP_ADDR14,
    OP_REL24,
    OP_REL32,
    OP_ADDR64,
    OP_HIGHER,
    OP_HIGHERA,
    OP_HIGHEST,
    OP_HIGHESTA,
    OP_REL64,
    OP_TOC,
    OP_DS,
    OP_LO_DS,
    OP_REL_LO,
    OP_REL_HI,
    OP_REL_HA,
    OP_UNKNOWN
  } op_t;

  typedef struct packed {
    logic [4:0]         req_type;
    logic [63:0]        sym_value;
    logic signed [63:0] addend;
    logic [63:0]        section_base;
    logic [63:0]        place_offset;
    logic [31:0]        old_word;
  } reloc_req_t;

  typedef struct packed {
    logic [63:0] patch_value;
    form_t       patch_form;
    status_t     status;
  } reloc_rsp_t;

  // Classified item held between front and back
  typedef struct packed {
    op_t         op;
    logic [63:0] sym;
    logic [63:0] adj_addend;
    logic [63:0] place;
    logic [31:0] old_word;
  } queue_entry_t;

endpackage
`default_nettype wire

// ===== design/ppc64_relocation_patch_unit.sv =====
// A request taken on start is written to a queue slot, then summed in the sum stage,
// then registered in the output stage, where out_valid rises with its result.
// Throughput: one relocation per cycle; front decode, queue and two back stages
// each move one entry a cycle, and the back end drains the queue every cycle,
// so the queue never fills and busy stays low.
// Reset (rst_n low, synchronous) clears GOT and PLT addresses, empties queue and
// pipeline; results of items in flight at reset are dropped.
`default_nettype none
module ppc64_relocation_patch_unit #(
  parameter int QUEUE_DEPTH = ppcrp_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ppcrp_pkg::reloc_req_t            in_req,
  output logic                                  out_valid,
  output ppcrp_pkg::reloc_rsp_t                 out_rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ppcrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                      cfg_data
);

  logic                    queue_full;
  logic                    push;
  ppcrp_pkg::queue_entry_t push_entry;
  logic                    pop;
  logic                    head_valid;
  ppcrp_pkg::queue_entry_t head_entry;

  assign busy = queue_full;

  ppcrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req     (in_req),
    .queue_full (queue_full),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  ppcrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  ppcrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp)
  );

endmodule
`default_nettype wire

// ===== design/ppcrp_front.sv =====
// Front end: configuration registers, TOC base, kind decode and place sum.
// Pushes one classified entry per accepted transfer. Depends on ppcrp_pkg.
`default_nettype none
module ppcrp_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire ppcrp_pkg::reloc_req_t              in_req,
  input  wire logic                               queue_full,
  input  wire logic                               cfg_valid,
  input  wire logic [ppcrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [63:0]                        cfg_data,
  output logic                                    cfg_ready,
  output logic                                    push,
  output ppcrp_pkg::queue_entry_t                 push_entry
);

  logic [63:0] got_r, got_nxt;
  logic [63:0] plt_r, plt_nxt;
  logic [63:0] tb_r,  tb_nxt;
  logic        cfg_wr;
  ppcrp_pkg::op_t op;
  logic        toc_adj;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // Keep the TOC base registered; recompute it from the value being written
  always_comb begin
    got_nxt = got_r;
    plt_nxt = plt_r;
    tb_nxt  = tb_r;
    if (cfg_wr) begin
      case (cfg_index)
        ppcrp_pkg::CFG_GOT_ADDRESS: begin
          got_nxt = cfg_data;
          tb_nxt  = ((cfg_data != 64'd0) ? cfg_data : plt_r) + ppcrp_pkg::TOC_BIAS;
        end
        ppcrp_pkg::CFG_PLT_ADDRESS: begin
          plt_nxt = cfg_data;
          tb_nxt  = ((got_r != 64'd0) ? got_r : cfg_data) + ppcrp_pkg::TOC_BIAS;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      got_r <= 64'd0;
      plt_r <= 64'd0;
      tb_r  <= ppcrp_pkg::TOC_BIAS;
    end else begin
      got_r <= got_nxt;
      plt_r <= plt_nxt;
      tb_r  <= tb_nxt;
    end
  end

  always_comb begin
    op      = ppcrp_pkg::OP_UNKNOWN;
    toc_adj = 1'b0;
    case (in_req.req_type)
      ppcrp_pkg::KIND_ADDR32:          op = ppcrp_pkg::OP_ADDR32;
      ppcrp_pkg::KIND_ADDR16:          op = ppcrp_pkg::OP_LO;
      ppcrp_pkg::KIND_ADDR16_LO:       op = ppcrp_pkg::OP_LO;
      ppcrp_pkg::KIND_ADDR16_HI:       op = ppcrp_pkg::OP_HI;
      ppcrp_pkg::KIND_ADDR16_HA:       op = ppcrp_pkg::OP_HA;
      ppcrp_pkg::KIND_ADDR14:          op = ppcrp_pkg::OP_ADDR14;
      ppcrp_pkg::KIND_REL24:           op = ppcrp_pkg::OP_REL24;
      ppcrp_pkg::KIND_REL32:           op = ppcrp_pkg::OP_REL32;
      ppcrp_pkg::KIND_ADDR64:          op = ppcrp_pkg::OP_ADDR64;
      ppcrp_pkg::KIND_ADDR16_HIGHER:   op = ppcrp_pkg::OP_HIGHER;
      ppcrp_pkg::KIND_ADDR16_HIGHERA:  op = ppcrp_pkg::OP_HIGHERA;
      ppcrp_pkg::KIND_ADDR16_HIGHEST:  op = ppcrp_pkg::OP_HIGHEST;
      ppcrp_pkg::KIND_ADDR16_HIGHESTA: op = ppcrp_pkg::OP_HIGHESTA;
      ppcrp_pkg::KIND_REL64:           op = ppcrp_pkg::OP_REL64;
      ppcrp_pkg::KIND_TOC16: begin
        op = ppcrp_pkg::OP_LO; toc_adj = 1'b1;
      end
      ppcrp_pkg::KIND_TOC16_LO: begin
        op = ppcrp_pkg::OP_LO; toc_adj = 1'b1;
      end
      ppcrp_pkg::KIND_TOC16_HI: begin
        op = ppcrp_pkg::OP_HI; toc_adj = 1'b1;
      end
      ppcrp_pkg::KIND_TOC16_HA: begin
        op = ppcrp_pkg::OP_HA; toc_adj = 1'b1;
      end
      ppcrp_pkg::KIND_TOC:             op = ppcrp_pkg::OP_TOC;
      ppcrp_pkg::KIND_ADDR16_DS:       op = ppcrp_pkg::OP_DS;
      ppcrp_pkg::KIND_ADDR16_LO_DS:    op = ppcrp_pkg::OP_LO_DS;
      ppcrp_pkg::KIND_TOC16_DS: begin
        op = ppcrp_pkg::OP_DS; toc_adj = 1'b1;
      end
      ppcrp_pkg::KIND_TOC16_LO_DS: begin
        op = ppcrp_pkg::OP_LO_DS; toc_adj = 1'b1;
      end
      ppcrp_pkg::KIND_REL16_LO:        op = ppcrp_pkg::OP_REL_LO;
      ppcrp_pkg::KIND_REL16_HI:        op = ppcrp_pkg::OP_REL_HI;
      ppcrp_pkg::KIND_REL16_HA:        op = ppcrp_pkg::OP_REL_HA;
      default: begin
        op = ppcrp_pkg::OP_UNKNOWN;
      end
    endcase
  end

  assign push = start & ~queue_full;

  always_comb begin
    push_entry.op       = op;
    push_entry.place    = in_req.section_base + in_req.place_offset;
    push_entry.old_word = in_req.old_word;
    if (op == ppcrp_pkg::OP_TOC) begin
      // Route the TOC base through the symbol sum so the back end sees R = TB
      push_entry.sym        = 64'd0;
      push_entry.adj_addend = tb_r;
    end else begin
      push_entry.sym        = in_req.sym_value;
      push_entry.adj_addend = toc_adj ? (in_req.addend - tb_r) : in_req.addend;
    end
  end

endmodule
`default_nettype wire

// ===== design/ppcrp_queue.sv =====
// Short register queue between front and back end.
// Holds classified entries; depends on ppcrp_pkg for the entry type.
`default_nettype none
module ppcrp_queue #(
  parameter int DEPTH = ppcrp_pkg::QUEUE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire ppcrp_pkg::queue_entry_t  push_entry,
  input  wire logic                     pop,
  output logic                          full,
  output logic                          head_valid,
  output ppcrp_pkg::queue_entry_t       head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppcrp_pkg::queue_entry_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== design/ppcrp_back.sv =====
// Back end: symbol sum stage, then place difference, field select and checks.
// Drains the queue every cycle; depends on ppcrp_pkg.
`default_nettype none
module ppcrp_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     head_valid,
  input  wire ppcrp_pkg::queue_entry_t  head_entry,
  output logic                          pop,
  output logic                          out_valid,
  output ppcrp_pkg::reloc_rsp_t         out_rsp
);

  // Stage 1: R = S + A
  logic           s1_valid_r;
  ppcrp_pkg::op_t s1_op_r;
  logic [63:0]    s1_r_r;
  logic [63:0]    s1_place_r;
  logic [31:0]    s1_old_r;

  // Stage 2 combinational
  logic [63:0]    r;
  logic [63:0]    d;
  logic [15:0]    r_ha;
  logic [15:0]    d_ha;
  logic [15:0]    r_highera;
  logic [15:0]    r_highesta;
  logic           r_fits32, r_fits16, d_fits32, d_fits26;
  ppcrp_pkg::reloc_rsp_t rsp_nxt;

  logic                  out_valid_r;
  ppcrp_pkg::reloc_rsp_t out_rsp_r;

  assign pop = head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= head_entry.op;
    s1_r_r     <= head_entry.sym + head_entry.adj_addend;
    s1_place_r <= head_entry.place;
    s1_old_r   <= head_entry.old_word;
  end

  assign r = s1_r_r;
  assign d = s1_r_r - s1_place_r;

  // High-adjusted halves: add the carry out of the rounding bias
  assign r_ha       = r[31:16] + {15'd0, r[15]};
  assign d_ha       = d[31:16] + {15'd0, d[15]};
  assign r_highera  = r[47:32] + {15'd0, r[15] & (&r[31:16])};
  assign r_highesta = r[63:48] + {15'd0, r[15] & (&r[47:16])};

  // Signed fit: all bits from the sign position up agree
  assign r_fits32 = (&r[63:31]) | ~(|r[63:31]);
  assign r_fits16 = (&r[63:15]) | ~(|r[63:15]);
  assign d_fits32 = (&d[63:31]) | ~(|d[63:31]);
  assign d_fits26 = (&d[63:25]) | ~(|d[63:25]);

  always_comb begin
    rsp_nxt.patch_value = 64'd0;
    rsp_nxt.patch_form  = ppcrp_pkg::FORM_HALF_AT_OFS;
    rsp_nxt.status      = ppcrp_pkg::STAT_OK;
    case (s1_op_r)
      ppcrp_pkg::OP_ADDR32: begin
        rsp_nxt.patch_value = {32'd0, r[31:0]};
        rsp_nxt.patch_form  = ppcrp_pkg::FORM_WORD32;
        if (!r_fits32) rsp_nxt.status = ppcrp_pkg::STAT_OVERFLOW;
      end
      ppcrp_pkg::OP_LO:      rsp_nxt.patch_value = {48'd0, r[15:0]};
      ppcrp_pkg::OP_HI:      rsp_nxt.patch_value = {48'd0, r[31:16]};
      ppcrp_pkg::OP_HA:      rsp_nxt.patch_value = {48'd0, r_ha};
      ppcrp_pkg::OP_ADDR14: begin
        rsp_nxt.patch_value = {48'd0, r[15:2], s1_old_r[1:0]};
        rsp_nxt.patch_form  = ppcrp_pkg::FORM_HALF_AT_OFS2;
        if (r[1:0] != 2'd0) rsp_nxt.status = ppcrp_pkg::STAT_MISALIGNED;
      end
      ppcrp_pkg::OP_REL24: begin
        rsp_nxt.patch_value = {32'd0, (s1_old_r & ~ppcrp_pkg::REL24_MASK) |
                                      (d[31:0] & ppcrp_pkg::REL24_MASK)};
        rsp_nxt.patch_form  = ppcrp_pkg::FORM_WORD32;
        if (!d_fits26) rsp_nxt.status = ppcrp_pkg::STAT_OVERFLOW;
      end
      ppcrp_pkg::OP_REL32: begin
        rsp_nxt.patch_value = {32'd0, d[31:0]};
        rsp_nxt.patch_form  = ppcrp_pkg::FORM_WORD32;
        if (!d_fits32) rsp_nxt.status = ppcrp_pkg::STAT_OVERFLOW;
      end
      ppcrp_pkg::OP_ADDR64, ppcrp_pkg::OP_TOC: begin
        rsp_nxt.patch_value = r;
        rsp_nxt.patch_form  = ppcrp_pkg::FORM_DWORD64;
      end
      ppcrp_pkg::OP_HIGHER:   rsp_nxt.patch_value = {48'd0, r[47:32]};
      ppcrp_pkg::OP_HIGHERA:  rsp_nxt.patch_value = {48'd0, r_highera};
      ppcrp_pkg::OP_HIGHEST:  rsp_nxt.patch_value = {48'd0, r[63:48]};
      ppcrp_pkg::OP_HIGHESTA: rsp_nxt.patch_value = {48'd0, r_highesta};
      ppcrp_pkg::OP_REL64: begin
        rsp_nxt.patch_value = d;
        rsp_nxt.patch_form  = ppcrp_pkg::FORM_DWORD64;
      end
      ppcrp_pkg::OP_DS: begin
        rsp_nxt.patch_value = {48'd0, r[15:2], s1_old_r[17:16]};
        if (!r_fits16) rsp_nxt.status = ppcrp_pkg::STAT_OVERFLOW;
      end
      ppcrp_pkg::OP_LO_DS:   rsp_nxt.patch_value = {48'd0, r[15:2], s1_old_r[17:16]};
      ppcrp_pkg::OP_REL_LO:  rsp_nxt.patch_value = {48'd0, d[15:0]};
      ppcrp_pkg::OP_REL_HI:  rsp_nxt.patch_value = {48'd0, d[31:16]};
      ppcrp_pkg::OP_REL_HA:  rsp_nxt.patch_value = {48'd0, d_ha};
      default: begin
        rsp_nxt.status = ppcrp_pkg::STAT_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

// ===== design/ppcrp_checker.sv =====
// Port-level checks for ppc64_relocation_patch_unit, bound to the top level.
// Depends on ppcrp_pkg for the payload types and codes.
`default_nettype none
module ppcrp_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             out_valid,
  input wire ppcrp_pkg::reloc_rsp_t            out_rsp
);

  // Every transfer in yields exactly one result strobe
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted relocation produced no result");

  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result strobe without a matching transfer");

  a_unknown_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ppcrp_pkg::STAT_UNKNOWN) |->
      (out_rsp.patch_value == 64'd0 && out_rsp.patch_form == ppcrp_pkg::FORM_HALF_AT_OFS))
    else $error("unknown kind wrote a value");

  a_half_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.patch_form == ppcrp_pkg::FORM_HALF_AT_OFS ||
                   out_rsp.patch_form == ppcrp_pkg::FORM_HALF_AT_OFS2)) |->
      (out_rsp.patch_value[63:16] == 48'd0))
    else $error("16-bit patch value wider than 16 bits");

  a_word_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.patch_form == ppcrp_pkg::FORM_WORD32) |->
      (out_rsp.patch_value[63:32] == 32'd0))
    else $error("32-bit patch value wider than 32 bits");

endmodule

bind ppc64_relocation_patch_unit ppcrp_checker u_ppcrp_checker (.*);
`default_nettype wire

// ===== dv/reloc_patch_checker.sv =====
// Checker for the PPC64 relocation patch unit: predicts each patch and compares.
// Depends on ppcrp_pkg for the request/response structs and the kind codes.
`timescale 1ns / 1ps
module reloc_patch_checker
  import ppcrp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  reloc_req_t           in_req,
  input  logic                 out_valid,
  input  reloc_rsp_t           out_rsp,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output int unsigned          fail_count,
  output int unsigned          patches_due,
  output int unsigned          patches_checked,
  output int unsigned          faults_seen
);

  logic [63:0] got_base = '0;
  logic [63:0] plt_base = '0;
  reloc_rsp_t  due_patches[$];
  reloc_rsp_t  want;

  initial begin
    fail_count      = 0;
    patches_due     = 0;
    patches_checked = 0;
    faults_seen     = 0;
  end

  function automatic logic fits_signed(logic [63:0] v, int unsigned bits);
    logic [63:0] half;
    half = 64'd1 << (bits - 1);
    return ((v + half) >> bits) == 64'd0;
  endfunction

  function automatic reloc_rsp_t patch_of(reloc_req_t rq);
    logic [63:0] toc_base;
    logic [63:0] adj;
    logic [63:0] rel;
    logic [63:0] disp;
    logic [63:0] rel_ha;
    logic [4:0]  kind;
    reloc_rsp_t  rs;
    toc_base = ((got_base != 64'd0) ? got_base : plt_base) + TOC_BIAS;
    adj  = rq.addend;
    kind = rq.req_type;
    // fold TOC-relative kinds onto their absolute twins
    case (kind)
      KIND_TOC16:       begin kind = KIND_ADDR16;       adj = adj - toc_base; end
      KIND_TOC16_LO:    begin kind = KIND_ADDR16_LO;    adj = adj - toc_base; end
      KIND_TOC16_HI:    begin kind = KIND_ADDR16_HI;    adj = adj - toc_base; end
      KIND_TOC16_HA:    begin kind = KIND_ADDR16_HA;    adj = adj - toc_base; end
      KIND_TOC16_DS:    begin kind = KIND_ADDR16_DS;    adj = adj - toc_base; end
      KIND_TOC16_LO_DS: begin kind = KIND_ADDR16_LO_DS; adj = adj - toc_base; end
      default: ;
    endcase
    rel    = rq.sym_value + adj;
    disp   = rel - (rq.section_base + rq.place_offset);
    rel_ha = rel + TOC_BIAS;
    rs.patch_value = '0;
    rs.patch_form  = FORM_HALF_AT_OFS;
    rs.status      = STAT_OK;
    case (kind)
      KIND_ADDR32: begin
        rs.patch_value = {32'd0, rel[31:0]};
        rs.patch_form  = FORM_WORD32;
        if (!fits_signed(rel, 32)) rs.status = STAT_OVERFLOW;
      end
      KIND_ADDR16, KIND_ADDR16_LO: rs.patch_value = {48'd0, rel[15:0]};
      KIND_ADDR16_HI:              rs.patch_value = {48'd0, rel[31:16]};
      KIND_ADDR16_HA:              rs.patch_value = {48'd0, rel_ha[31:16]};
      KIND_ADDR14: begin
        rs.patch_value = {48'd0, rel[15:2], rq.old_word[1:0]};
        rs.patch_form  = FORM_HALF_AT_OFS2;
        if (rel[1:0] != 2'b00) rs.status = STAT_MISALIGNED;
      end
      KIND_REL24: begin
        rs.patch_value = {32'd0, (rq.old_word & ~REL24_MASK) | (disp[31:0] & REL24_MASK)};
        rs.patch_form  = FORM_WORD32;
        if (!fits_signed(disp, 26)) rs.status = STAT_OVERFLOW;
      end
      KIND_REL32: begin
        rs.patch_value = {32'd0, disp[31:0]};
        rs.patch_form  = FORM_WORD32;
        if (!fits_signed(disp, 32)) rs.status = STAT_OVERFLOW;
      end
      KIND_ADDR64: begin
        rs.patch_value = rel;
        rs.patch_form  = FORM_DWORD64;
      end
      KIND_ADDR16_HIGHER:   rs.patch_value = {48'd0, rel[47:32]};
      KIND_ADDR16_HIGHERA:  rs.patch_value = {48'd0, rel_ha[47:32]};
      KIND_ADDR16_HIGHEST:  rs.patch_value = {48'd0, rel[63:48]};
      KIND_ADDR16_HIGHESTA: rs.patch_value = {48'd0, rel_ha[63:48]};
      KIND_REL64: begin
        rs.patch_value = disp;
        rs.patch_form  = FORM_DWORD64;
      end
      KIND_TOC: begin
        rs.patch_value = toc_base;
        rs.patch_form  = FORM_DWORD64;
      end
      KIND_ADDR16_DS: begin
        rs.patch_value = {48'd0, rel[15:2], rq.old_word[17:16]};
        if (!fits_signed(rel, 16)) rs.status = STAT_OVERFLOW;
      end
      KIND_ADDR16_LO_DS: rs.patch_value = {48'd0, rel[15:2], rq.old_word[17:16]};
      KIND_REL16_LO:     rs.patch_value = {48'd0, disp[15:0]};
      KIND_REL16_HI:     rs.patch_value = {48'd0, disp[31:16]};
      KIND_REL16_HA:     rs.patch_value = {48'd0, disp[31:16] + {15'd0, disp[15]}};
      default:           rs.status = STAT_UNKNOWN;
    endcase
    return rs;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    $display("MISMATCH %s: seen %h, predicted %h at %0t", what, seen, wanted, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_patches.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GOT_ADDRESS) got_base = cfg_data;
        else if (cfg_index == CFG_PLT_ADDRESS) plt_base = cfg_data;
      end
      if (out_valid) begin
        if (due_patches.size() == 0) begin
          report_mismatch("patch with none outstanding", out_rsp.patch_value, 64'd0);
        end else begin
          want = due_patches.pop_front();
          patches_checked++;
          if (want.status != STAT_OK) faults_seen++;
          if (out_rsp.patch_value !== want.patch_value)
            report_mismatch("patch_value", out_rsp.patch_value, want.patch_value);
          if (out_rsp.patch_form !== want.patch_form)
            report_mismatch("patch_form", 64'(out_rsp.patch_form), 64'(want.patch_form));
          if (out_rsp.status !== want.status)
            report_mismatch("status", 64'(out_rsp.status), 64'(want.status));
        end
      end
      if (start && !busy) due_patches.push_back(patch_of(in_req));
    end
    patches_due = due_patches.size();
  end

endmodule

// ===== dv/tb.sv =====
// Top of the relocation patch unit testbench: clock, reset, stimulus and verdict.
// Depends on ppcrp_pkg, the block itself and reloc_patch_checker.
`timescale 1ns / 1ps
module tb;
  import ppcrp_pkg::*;

  localparam int unsigned LATENCY     = 3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PER_PHASE   = 170;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  reloc_req_t           in_req    = '0;
  logic                 out_valid;
  reloc_rsp_t           out_rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data  = '0;

  int unsigned fail_count, patches_due, patches_checked, faults_seen;
  int unsigned cycles      = 0;
  int unsigned relocs_sent = 0;
  logic        allow_idle  = 1'b1;
  logic [63:0] cur_got     = '0;
  logic [63:0] cur_plt     = '0;

  always #5 clk = ~clk;

  ppc64_relocation_patch_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reloc_patch_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req          (in_req),
    .out_valid       (out_valid),
    .out_rsp         (out_rsp),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .patches_due     (patches_due),
    .patches_checked (patches_checked),
    .faults_seen     (faults_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d patches outstanding", cycles, patches_due);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Displacement or address of a chosen magnitude, often hugging a range limit
  function automatic logic [63:0] pick_target();
    logic [63:0]        v;
    logic signed [63:0] t;
    logic [63:0]        lim;
    int unsigned        b;
    v = rand64();
    case ($urandom_range(0, 2))
      0:       b = 16;
      1:       b = 26;
      default: b = 32;
    endcase
    case ($urandom_range(0, 5))
      0: begin
        t = v << 48;
        v = t >>> 48;
      end
      1: begin
        t = v << 38;
        v = t >>> 38;
      end
      2: begin
        t = v << 32;
        v = t >>> 32;
      end
      3: ;
      4: begin
        lim = 64'd1 << (b - 1);
        if ($urandom_range(0, 1)) v = lim - 64'd1 + 64'($urandom_range(0, 1));
        else v = -lim - 64'($urandom_range(0, 1));
      end
      default: begin
        t = v << 55;
        v = t >>> 55;
      end
    endcase
    if ($urandom_range(0, 1)) v[1:0] = 2'b00;
    return v;
  endfunction

  function automatic reloc_req_t make_reloc(logic [4:0] kind);
    reloc_req_t         rq;
    logic [63:0]        toc_base;
    logic [63:0]        target;
    logic signed [63:0] t;
    toc_base        = ((cur_got != 64'd0) ? cur_got : cur_plt) + TOC_BIAS;
    rq.req_type     = kind;
    rq.addend       = rand64();
    if ($urandom_range(0, 1)) begin
      t         = rq.addend << 48;
      rq.addend = t >>> 48;
    end
    rq.section_base = rand64();
    rq.place_offset = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 65535));
    rq.old_word     = $urandom;
    target          = pick_target();
    // steer S so that R, or R - P for PC-relative kinds, lands on the target
    case (kind)
      KIND_REL24, KIND_REL32, KIND_REL64, KIND_REL16_LO, KIND_REL16_HI, KIND_REL16_HA:
        rq.sym_value = target + rq.section_base + rq.place_offset - rq.addend;
      KIND_TOC16, KIND_TOC16_LO, KIND_TOC16_HI, KIND_TOC16_HA,
      KIND_TOC16_DS, KIND_TOC16_LO_DS:
        rq.sym_value = target - rq.addend + toc_base;
      default:
        rq.sym_value = target - rq.addend;
    endcase
    if ($urandom_range(0, 9) == 0) rq.sym_value = rand64();
    return rq;
  endfunction

  task automatic send_reloc(input reloc_req_t rq);
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk) start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    @(negedge clk);
    start  <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (busy);
    relocs_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    if (idx == CFG_GOT_ADDRESS) cur_got = value;
    else if (idx == CFG_PLT_ADDRESS) cur_plt = value;
  endtask

  // Hold start low until every patch has come back, then let the pipe empty
  task automatic settle();
    @(negedge clk) start <= 1'b0;
    while (patches_due != 0) @(negedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    reloc_req_t rq;
    logic [4:0] kind;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: every kind once with picked targets, then unknown codes at the extremes
    for (int k = 0; k <= int'(KIND_REL16_HA); k++) begin
      send_reloc(make_reloc(5'(k)));
    end
    rq          = '0;
    rq.req_type = 5'd26;
    send_reloc(rq);
    rq          = '1;
    send_reloc(rq);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: begin
            write_reg(CFG_GOT_ADDRESS, 64'd0);
            write_reg(CFG_PLT_ADDRESS, rand64());
          end
          2: begin
            write_reg(CFG_GOT_ADDRESS, rand64());
            write_reg(CFG_PLT_ADDRESS, rand64());
          end
          3: begin
            // TOC base wraps past the top of the address space
            write_reg(CFG_GOT_ADDRESS, '1);
            write_reg(CFG_PLT_ADDRESS, 64'd0);
          end
          4: begin
            write_reg(CFG_GOT_ADDRESS, 64'd0);
            write_reg(CFG_PLT_ADDRESS, '1);
          end
          default: begin
            // TOC base lands on zero; the spare index must change nothing
            write_reg(CFG_GOT_ADDRESS, -TOC_BIAS);
            write_reg(CFG_PLT_ADDRESS, rand64());
            write_reg(CFG_SPARE_IDX, rand64());
            allow_idle = 1'b0;
          end
        endcase
      end
      for (int i = 0; i < PER_PHASE; i++) begin
        if ($urandom_range(0, 19) == 0) kind = 5'($urandom_range(26, 31));
        else kind = 5'($urandom_range(0, int'(KIND_REL16_HA)));
        send_reloc(make_reloc(kind));
      end
    end
    settle();

    $display("Sent %0d relocations across %0d GOT/PLT settings, all 32 kind codes.",
             relocs_sent, PHASES);
    $display("Checked %0d patches, %0d of them with a fault or unknown status.",
             patches_checked, faults_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
